@@ src/srs_pkg.sv @@
package srs_pkg;

   localparam int unsigned OUTPUT_RATE_DEF = 44100;

   localparam int unsigned SAMPLE_W   = 16;
   localparam int unsigned PHASE_W    = 18;
   localparam int unsigned POS_W      = PHASE_W + 1;
   localparam int unsigned FRAC_W     = 16;
   localparam int unsigned GAIN_W     = 16;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 18;

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_RATE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_GAIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MONO_SOURCE = 2'd2;

   localparam logic [PHASE_W-1:0] SOURCE_RATE_RST = 18'd44100;
   localparam logic [GAIN_W-1:0]  SAMPLE_GAIN_RST = 16'd32768;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [FRAC_W-1:0] frac_type;

   typedef struct packed {
      sample_type left_in;
      sample_type right_in;
      logic       final_frame;
   } req_type;

   typedef struct packed {
      sample_type left_out;
      sample_type right_out;
      logic       frame_valid;
      logic       track_end;
   } rsp_type;

   typedef struct packed {
      logic frame_valid;
      logic track_end;
   } flag_type;

   // segment end points for both channels plus result flags
   typedef struct packed {
      sample_type l0;
      sample_type l1;
      sample_type r0;
      sample_type r1;
      flag_type   flags;
   } side_type;

   typedef struct packed {
      logic               valid;
      logic [PHASE_W-1:0] pos;
      side_type           side;
   } iss_type;

   typedef struct packed {
      logic     valid;
      frac_type frac;
      side_type side;
   } phs_type;

endpackage

@@ src/stereo_linear_resampler.sv @@
// Per item the sequencer takes it, issues each output frame, and closes each segment
// (none for an opening frame that is not final, up to 2 on a final frame), one item at
// a time. Output frames leave at most one per cycle.
// From item accept to first result: sequencer, 3 phase, 2 lane stages, output register; a
// stalled result freezes all stages, though an idle sequencer still accepts a new item.
// Synchronous reset restores register defaults, clears held frame and phase; ready next cycle.
module stereo_linear_resampler #(
   parameter int unsigned OUTPUT_RATE = srs_pkg::OUTPUT_RATE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  srs_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output srs_pkg::rsp_type                rsp_data,
   input  logic                            csr_wr_en,
   input  logic [srs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [srs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import srs_pkg::*;

   logic [PHASE_W-1:0] source_rate_ff;
   logic [GAIN_W-1:0]  sample_gain_ff;
   logic               mono_source_ff;

   logic       adv;
   iss_type    iss;
   phs_type    phs;
   sample_type lane_l, lane_r;
   logic       v1_ff, v2_ff;
   flag_type   fl1_ff, fl2_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   // whole datapath moves unless a result sits stalled at the output
   assign adv = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_rate_ff <= SOURCE_RATE_RST;
         sample_gain_ff <= SAMPLE_GAIN_RST;
         mono_source_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SOURCE_RATE: source_rate_ff <= csr_wdata[PHASE_W-1:0];
            CSR_SAMPLE_GAIN: sample_gain_ff <= csr_wdata[GAIN_W-1:0];
            CSR_MONO_SOURCE: mono_source_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   srs_seq #(.OUTPUT_RATE(OUTPUT_RATE)) u_seq (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .source_rate (source_rate_ff),
      .mono_source (mono_source_ff),
      .iss         (iss)
   );

   srs_phase #(.OUTPUT_RATE(OUTPUT_RATE)) u_phase (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .iss   (iss),
      .phs   (phs)
   );

   srs_lane u_lane_l (
      .clock  (clock),
      .adv    (adv),
      .s0     (phs.side.l0),
      .s1     (phs.side.l1),
      .frac   (phs.frac),
      .gain   (sample_gain_ff),
      .sample (lane_l)
   );

   srs_lane u_lane_r (
      .clock  (clock),
      .adv    (adv),
      .s0     (phs.side.r0),
      .s1     (phs.side.r1),
      .frac   (phs.frac),
      .gain   (sample_gain_ff),
      .sample (lane_r)
   );

   // merge both lanes with the flags that traveled alongside
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (adv) begin
         rsp_valid_in       = v2_ff;
         rsp_in.left_out    = fl2_ff.frame_valid ? lane_l : '0;
         rsp_in.right_out   = fl2_ff.frame_valid ? lane_r : '0;
         rsp_in.frame_valid = fl2_ff.frame_valid;
         rsp_in.track_end   = fl2_ff.track_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            v1_ff <= phs.valid;
            v2_ff <= v1_ff;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fl1_ff <= phs.side.flags;
         fl2_ff <= fl1_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ src/srs_seq.sv @@
module srs_seq #(
   parameter int unsigned OUTPUT_RATE = srs_pkg::OUTPUT_RATE_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  srs_pkg::req_type             req_data,
   input  logic [srs_pkg::PHASE_W-1:0]  source_rate,
   input  logic                         mono_source,
   output srs_pkg::iss_type             iss
);
   import srs_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SEG1 = 2'd1;
   localparam logic [1:0] ST_SEG2 = 2'd2;

   localparam logic [POS_W-1:0]   OUT_RATE   = POS_W'(OUTPUT_RATE);
   localparam logic [POS_W-1:0]   OUT_RATE2  = POS_W'(2 * OUTPUT_RATE);
   localparam logic [PHASE_W-1:0] RATE_FLOOR = PHASE_W'((OUTPUT_RATE + 5) / 6);

   logic [1:0]         state_ff, state_in;
   logic               have_held_ff, have_held_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   sample_type         held_l_ff, held_l_in;
   sample_type         held_r_ff, held_r_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [PHASE_W-1:0] rate_ff, rate_in;
   sample_type         a0_ff, a0_in, a1_ff, a1_in;
   sample_type         b0_ff, b0_in, b1_ff, b1_in;
   logic               fin_ff, fin_in;
   logic               emitted_ff, emitted_in;
   iss_type            iss_ff, iss_in;

   logic [POS_W-1:0]   sum;
   logic [POS_W-1:0]   pos_wrap;
   sample_type         in_l, in_r;
   logic [PHASE_W-1:0] rate_sel;

   assign req_stall = (state_ff != ST_IDLE);
   assign iss       = iss_ff;

   always_comb begin
      sum      = pos_ff + POS_W'(rate_ff);
      pos_wrap = pos_ff - OUT_RATE;
      in_l     = req_data.left_in;
      in_r     = mono_source ? req_data.left_in : req_data.right_in;
      rate_sel = (source_rate < RATE_FLOOR) ? RATE_FLOOR : source_rate;

      state_in     = state_ff;
      have_held_in = have_held_ff;
      phase_in     = phase_ff;
      held_l_in    = held_l_ff;
      held_r_in    = held_r_ff;
      pos_in       = pos_ff;
      rate_in      = rate_ff;
      a0_in        = a0_ff;
      a1_in        = a1_ff;
      b0_in        = b0_ff;
      b1_in        = b1_ff;
      fin_in       = fin_ff;
      emitted_in   = emitted_ff;
      iss_in       = iss_ff;
      if (adv) begin
         iss_in.valid = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               held_l_in    = in_l;
               held_r_in    = in_r;
               have_held_in = 1'b1;
               fin_in       = req_data.final_frame;
               emitted_in   = 1'b0;
               rate_in      = rate_sel;
               a1_in        = in_l;
               b1_in        = in_r;
               pos_in       = POS_W'(phase_ff);
               if (have_held_ff) begin
                  a0_in    = held_l_ff;
                  b0_in    = held_r_ff;
                  state_in = ST_SEG1;
               end else if (req_data.final_frame) begin
                  a0_in    = in_l;
                  b0_in    = in_r;
                  state_in = ST_SEG2;
               end
            end
         end
         ST_SEG1: begin
            if (adv) begin
               if (pos_ff < OUT_RATE) begin
                  iss_in.valid                   = 1'b1;
                  iss_in.pos                     = pos_ff[PHASE_W-1:0];
                  iss_in.side.l0                 = a0_ff;
                  iss_in.side.l1                 = a1_ff;
                  iss_in.side.r0                 = b0_ff;
                  iss_in.side.r1                 = b1_ff;
                  iss_in.side.flags.frame_valid  = 1'b1;
                  // last of the track when the flush segment will be empty
                  iss_in.side.flags.track_end    = fin_ff && (sum >= OUT_RATE2);
                  pos_in                         = sum;
                  emitted_in                     = 1'b1;
               end else begin
                  phase_in = pos_wrap[PHASE_W-1:0];
                  if (fin_ff) begin
                     a0_in    = a1_ff;
                     b0_in    = b1_ff;
                     pos_in   = pos_wrap;
                     state_in = ST_SEG2;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_SEG2: begin
            if (adv) begin
               if (pos_ff < OUT_RATE) begin
                  iss_in.valid                   = 1'b1;
                  iss_in.pos                     = pos_ff[PHASE_W-1:0];
                  iss_in.side.l0                 = a0_ff;
                  iss_in.side.l1                 = a1_ff;
                  iss_in.side.r0                 = b0_ff;
                  iss_in.side.r1                 = b1_ff;
                  iss_in.side.flags.frame_valid  = 1'b1;
                  iss_in.side.flags.track_end    = (sum >= OUT_RATE);
                  pos_in                         = sum;
                  emitted_in                     = 1'b1;
               end else begin
                  if (!emitted_ff) begin
                     // empty track tail: a lone end marker
                     iss_in.valid                  = 1'b1;
                     iss_in.pos                    = '0;
                     iss_in.side                   = '0;
                     iss_in.side.flags.track_end   = 1'b1;
                  end
                  held_l_in    = '0;
                  held_r_in    = '0;
                  have_held_in = 1'b0;
                  phase_in     = '0;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         have_held_ff <= 1'b0;
         phase_ff     <= '0;
         held_l_ff    <= '0;
         held_r_ff    <= '0;
         iss_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         have_held_ff <= have_held_in;
         phase_ff     <= phase_in;
         held_l_ff    <= held_l_in;
         held_r_ff    <= held_r_in;
         iss_ff       <= iss_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      rate_ff    <= rate_in;
      a0_ff      <= a0_in;
      a1_ff      <= a1_in;
      b0_ff      <= b0_in;
      b1_ff      <= b1_in;
      fin_ff     <= fin_in;
      emitted_ff <= emitted_in;
   end

endmodule

@@ src/srs_phase.sv @@
module srs_phase #(
   parameter int unsigned OUTPUT_RATE = srs_pkg::OUTPUT_RATE_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  srs_pkg::iss_type iss,
   output srs_pkg::phs_type phs
);
   import srs_pkg::*;

   // frac = floor(pos * 2^16 / OUTPUT_RATE) by reciprocal, then one fix-up step
   localparam int unsigned  RECIP_SHIFT = PHASE_W;
   localparam logic [63:0]  RECIP = (64'd1 << (FRAC_W + RECIP_SHIFT)) / 64'(OUTPUT_RATE);
   localparam int unsigned  MW = $clog2(RECIP + 64'd1);
   localparam int unsigned  PROD_W = PHASE_W + MW;
   localparam int unsigned  TE_W = FRAC_W + 1;
   localparam int unsigned  HI_W = TE_W + PHASE_W;
   localparam logic [MW-1:0]      RECIP_C = RECIP[MW-1:0];
   localparam logic [PHASE_W-1:0] OUT_RATE = PHASE_W'(OUTPUT_RATE);

   logic               v1_ff, v2_ff, v3_ff;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [PHASE_W-1:0] pos1_ff, pos2_ff;
   side_type           side1_ff, side2_ff, side3_ff;
   logic [TE_W-1:0]    te_ff, te_in, te_dec;
   logic [HI_W-1:0]    hi_ff, hi_in, scaled;
   frac_type           frac_ff, frac_in;

   always_comb begin
      prod_in = PROD_W'(iss.pos) * PROD_W'(RECIP_C);
      te_in   = {1'b0, prod_ff[RECIP_SHIFT +: FRAC_W]} + TE_W'(1);
      hi_in   = HI_W'(te_in) * HI_W'(OUT_RATE);
      scaled  = {1'b0, pos2_ff, FRAC_W'(0)};
      te_dec  = te_ff - TE_W'(1);
      frac_in = (hi_ff <= scaled) ? te_ff[FRAC_W-1:0] : te_dec[FRAC_W-1:0];
   end

   assign phs.valid = v3_ff;
   assign phs.frac  = frac_ff;
   assign phs.side  = side3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= iss.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff  <= prod_in;
         pos1_ff  <= iss.pos;
         side1_ff <= iss.side;
         te_ff    <= te_in;
         hi_ff    <= hi_in;
         pos2_ff  <= pos1_ff;
         side2_ff <= side1_ff;
         frac_ff  <= frac_in;
         side3_ff <= side2_ff;
      end
   end

endmodule

@@ src/srs_lane.sv @@
module srs_lane (
   input  logic                         clock,
   input  logic                         adv,
   input  srs_pkg::sample_type          s0,
   input  srs_pkg::sample_type          s1,
   input  srs_pkg::frac_type            frac,
   input  logic [srs_pkg::GAIN_W-1:0]   gain,
   output srs_pkg::sample_type          sample
);
   import srs_pkg::*;

   localparam int unsigned V_W = SAMPLE_W + FRAC_W + 1;
   localparam int unsigned P_W = V_W + GAIN_W + 1;
   localparam int unsigned Q_SHIFT = 31;
   localparam int unsigned Q_W = P_W - Q_SHIFT;
   localparam logic signed [P_W-1:0] ROUND = P_W'(64'd1 << (Q_SHIFT - 1));

   logic signed [SAMPLE_W:0]   diff;
   logic signed [V_W:0]        step;
   logic signed [V_W:0]        vsum;
   logic signed [V_W-1:0]      v_ff, v_in;
   logic signed [P_W-1:0]      vx, gx;
   logic signed [P_W-1:0]      p_ff, p_in;
   logic signed [Q_W-1:0]      q;

   always_comb begin
      diff = {s1[SAMPLE_W-1], s1} - {s0[SAMPLE_W-1], s0};
      step = (V_W+1)'(diff) * (V_W+1)'($signed({1'b0, frac}));
      vsum = {{2{s0[SAMPLE_W-1]}}, s0, FRAC_W'(0)} + step;
      v_in = vsum[V_W-1:0];
      vx   = P_W'(v_ff);
      gx   = $signed({{(P_W-GAIN_W){1'b0}}, gain});
      p_in = vx * gx + ROUND;
      q    = p_ff[P_W-1:Q_SHIFT];
      // saturate when the bits above the sample do not all match its sign
      if (q[Q_W-1:SAMPLE_W-1] == '0 || q[Q_W-1:SAMPLE_W-1] == '1) begin
         sample = q[SAMPLE_W-1:0];
      end else if (q[Q_W-1]) begin
         sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         v_ff <= v_in;
         p_ff <= p_in;
      end
   end

endmodule

@@ tb/stereo_linear_resampler_check.sv @@
module stereo_linear_resampler_check (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  srs_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  srs_pkg::rsp_type               rsp_data,
   input  logic                           csr_wr_en,
   input  logic [srs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [srs_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int unsigned                    mismatches,
   output int unsigned                    pending,
   output int unsigned                    frames_checked,
   output int unsigned                    tracks_closed
);
   import srs_pkg::*;

   localparam int unsigned OUT_RATE   = OUTPUT_RATE_DEF;
   localparam int unsigned RATE_FLOOR = (OUT_RATE + 5) / 6;
   localparam int unsigned MAX_FRAMES = 12;

   // register shadow
   logic [PHASE_W-1:0] src_rate = SOURCE_RATE_RST;
   logic [GAIN_W-1:0]  gain     = SAMPLE_GAIN_RST;
   logic               mono     = 1'b0;

   // held source frame and phase
   int                 held_l    = 0;
   int                 held_r    = 0;
   logic               have_held = 1'b0;
   logic [PHASE_W-1:0] phase     = '0;

   rsp_type frames_due[$];
   rsp_type step_frames[$];

   initial begin
      mismatches     = 0;
      pending        = 0;
      frames_checked = 0;
      tracks_closed  = 0;
   end

   // linear blend at phase ph, Q1.15 gain, rounded shift, saturate
   function automatic sample_type blend(input int s0, input int s1, input int unsigned ph);
      longint t;
      longint v;
      longint p;
      longint q;
      t = (longint'(ph) << 16) / OUT_RATE;
      v = longint'(s0) * 65536 + longint'(s1 - s0) * t;
      p = v * longint'(gain) + (longint'(1) << 30);
      q = p >>> 31;
      if (q > 32767) begin
         q = 32767;
      end else if (q < -32768) begin
         q = -32768;
      end
      return q[15:0];
   endfunction

   // output frames that fall between two source frames; returns advanced phase
   function automatic int unsigned sweep(input int a0, input int b0, input int a1, input int b1,
                                         input int unsigned ph, input int unsigned rate);
      rsp_type f;
      while (ph < OUT_RATE) begin
         if (step_frames.size() < MAX_FRAMES) begin
            f.left_out    = blend(a0, a1, ph);
            f.right_out   = blend(b0, b1, ph);
            f.frame_valid = 1'b1;
            f.track_end   = 1'b0;
            step_frames.push_back(f);
         end
         ph += rate;
      end
      return ph;
   endfunction

   function automatic void predict(input req_type item);
      int          l;
      int          r;
      int unsigned rate;
      int unsigned ph;
      rsp_type     last_frame;
      l    = int'(item.left_in);
      r    = mono ? l : int'(item.right_in);
      rate = (src_rate < RATE_FLOOR) ? RATE_FLOOR : int'(src_rate);
      ph   = phase;
      step_frames.delete();
      if (have_held) begin
         ph = sweep(held_l, held_r, l, r, ph, rate);
         ph -= OUT_RATE;
      end
      held_l    = l;
      held_r    = r;
      have_held = 1'b1;
      phase     = ph[PHASE_W-1:0];
      if (item.final_frame) begin
         // last frame pairs with itself to flush the tail
         ph = sweep(l, r, l, r, ph, rate);
         if (step_frames.size() == 0) begin
            last_frame = '{left_out: '0, right_out: '0, frame_valid: 1'b0, track_end: 1'b1};
         end else begin
            last_frame = step_frames.pop_back();
            last_frame.track_end = 1'b1;
         end
         step_frames.push_back(last_frame);
         held_l    = 0;
         held_r    = 0;
         have_held = 1'b0;
         phase     = '0;
      end
      foreach (step_frames[i]) frames_due.push_back(step_frames[i]);
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         src_rate  = SOURCE_RATE_RST;
         gain      = SAMPLE_GAIN_RST;
         mono      = 1'b0;
         held_l    = 0;
         held_r    = 0;
         have_held = 1'b0;
         phase     = '0;
         frames_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            frames_checked++;
            if (frames_due.size() == 0) begin
               mismatches++;
               $display("%0t: frame with nothing expected: L=%0d R=%0d valid=%b end=%b",
                        $time, rsp_data.left_out, rsp_data.right_out,
                        rsp_data.frame_valid, rsp_data.track_end);
            end else begin
               want = frames_due.pop_front();
               if (rsp_data !== want) begin
                  mismatches++;
                  $display("%0t: expected L=%0d R=%0d valid=%b end=%b, got L=%0d R=%0d valid=%b end=%b",
                           $time, want.left_out, want.right_out, want.frame_valid,
                           want.track_end, rsp_data.left_out, rsp_data.right_out,
                           rsp_data.frame_valid, rsp_data.track_end);
               end
               if (want.track_end) tracks_closed++;
            end
         end
         if (req_valid && !req_stall) predict(req_data);
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SOURCE_RATE: src_rate = csr_wdata[PHASE_W-1:0];
               CSR_SAMPLE_GAIN: gain = csr_wdata[GAIN_W-1:0];
               CSR_MONO_SOURCE: mono = csr_wdata[0];
               default: ;
            endcase
         end
      end
      pending = frames_due.size();
   end

endmodule

@@ tb/stereo_linear_resampler_test.sv @@
module stereo_linear_resampler_test;
   import srs_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned LONG_HOLD   = 300;
   localparam int unsigned DRAIN_WAIT  = 30;
   localparam int unsigned ITEM_TARGET = 380;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;  // no register here

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int unsigned mismatches;
   int unsigned pending;
   int unsigned frames_checked;
   int unsigned tracks_closed;

   int unsigned items_sent     = 0;
   int unsigned settings_used  = 0;
   int unsigned sender_calm    = 0;
   logic        quiet          = 1'b0;
   logic        hold_wanted    = 1'b0;
   logic        hold_done      = 1'b0;

   always #1 clock = ~clock;

   stereo_linear_resampler u_top (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_wr_en, .csr_index, .csr_wdata
   );

   stereo_linear_resampler_check u_check (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_wr_en, .csr_index, .csr_wdata,
      .mismatches, .pending, .frames_checked, .tracks_closed
   );

   function automatic req_type make_item(input int l, input int r, input logic fin);
      req_type item;
      item.left_in     = l[15:0];
      item.right_in    = r[15:0];
      item.final_frame = fin;
      return item;
   endfunction

   function automatic int pick_sample();
      case ($urandom_range(0, 9))
         0: return 32767;
         1: return -32768;
         2: return 0;
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   task automatic send(input req_type item);
      if (sender_calm > 0) begin
         sender_calm--;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
         sender_calm = 25;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // wait for every expected frame, then let the sequencer finish silent items
   task automatic settle();
      do @(negedge clock); while (pending != 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [PHASE_W-1:0] rate, input logic [GAIN_W-1:0] gain,
                             input logic mono);
      write_reg(CSR_SOURCE_RATE, rate);
      write_reg(CSR_SAMPLE_GAIN, {2'b00, gain});
      write_reg(CSR_MONO_SOURCE, {17'd0, mono});
      write_reg(CSR_SPARE, CSR_DATA_W'($urandom_range(0, 262143)));
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   task automatic random_config();
      logic [PHASE_W-1:0] rate;
      logic [GAIN_W-1:0]  gain;
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 5))
               0: rate = 18'd0;
               1: rate = 18'd7349;
               2: rate = 18'd7350;
               3: rate = 18'd8000;
               4: rate = 18'd192000;
               default: rate = 18'h3FFFF;
            endcase
         end
         1: rate = PHASE_W'($urandom_range(0, 262143));
         default: rate = PHASE_W'($urandom_range(8000, 192000));
      endcase
      case ($urandom_range(0, 5))
         0: gain = 16'd0;
         1: gain = 16'hFFFF;
         2: gain = SAMPLE_GAIN_RST;
         default: gain = GAIN_W'($urandom_range(0, 65535));
      endcase
      set_config(rate, gain, 1'($urandom_range(0, 1)));
   endtask

   // tracks of random length; the last one may run on into the next setting
   task automatic play_tracks(input int unsigned count);
      int unsigned left_over;
      int unsigned len;
      int unsigned cut;
      left_over = count;
      while (left_over > 0) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 6);
         cut = (len > left_over) ? left_over : len;
         for (int unsigned i = 0; i < cut; i++) begin
            send(make_item(pick_sample(), pick_sample(), (i == len - 1)));
         end
         left_over -= cut;
      end
   endtask

   initial begin : rsp_pacing
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (hold_wanted && !hold_done) begin
            // long hold so the block backs up into its input
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_done = 1'b1;
         end else if (!quiet && $urandom_range(0, 15) == 0) begin
            repeat (40) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int unsigned cycles_run;
      cycles_run = 0;
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("timeout after %0d cycles, %0d frames still due", cycles_run, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      int unsigned round;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: single-frame track, then full-scale swings
      send(make_item(32767, -32768, 1'b1));
      send(make_item(-32768, 32767, 1'b0));
      send(make_item(32767, -32768, 1'b0));
      send(make_item(0, 0, 1'b0));
      send(make_item(-1, 1, 1'b1));
      req_valid <= 1'b0;
      settle();

      // fast source, max gain, mono: last frame lands past every output slot
      set_config(18'd192000, 16'hFFFF, 1'b1);
      send(make_item(32767, 5, 1'b0));
      send(make_item(-32768, -5, 1'b0));
      send(make_item(100, 0, 1'b1));
      send(make_item(32767, 0, 1'b1));
      req_valid <= 1'b0;
      settle();

      // rate below floor, zero gain: twelve frames from one final item
      set_config(18'd0, 16'd0, 1'b0);
      send(make_item(12345, -12345, 1'b0));
      send(make_item(-32768, 32767, 1'b1));
      req_valid <= 1'b0;
      settle();

      set_config(18'd8000, SAMPLE_GAIN_RST, 1'b1);
      send(make_item(-32768, 32767, 1'b0));
      send(make_item(32767, -32768, 1'b1));
      req_valid <= 1'b0;
      settle();

      round = 0;
      while (items_sent < ITEM_TARGET) begin
         random_config();
         if (round == 2) hold_wanted = 1'b1;
         if (items_sent >= ITEM_TARGET - 60) quiet = 1'b1;
         play_tracks($urandom_range(25, 45));
         req_valid <= 1'b0;
         settle();
         round++;
      end

      $display("covered %0d items over %0d register settings plus reset values",
               items_sent, settings_used);
      $display("checked %0d output results, %0d track ends, %0d mismatches",
               frames_checked, tracks_closed, mismatches);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
